// ===== src/dpc_pkg.sv =====
`timescale 1ns / 1ps
package dpc_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRONT_STAGES  = 16;
    localparam int LOG_FRAC      = 28;
    localparam int LOG_ARG_BITS  = 17;
    localparam int LOG_BITS      = LOG_FRAC + 5;
    localparam int RATIO_STAGES  = 8;
    localparam int SIDE_DEPTH    = LOG_FRAC + RATIO_STAGES + 2;
    localparam int LATENCY       = FRONT_STAGES + SIDE_DEPTH + 3;

    localparam logic [LOG_BITS-1:0] LOG_OF_256 = LOG_BITS'(8) << LOG_FRAC;
    localparam logic [7:0]          LUM_SCALE  = 8'd255;

    localparam logic [7:0] COL_INVALID  = 8'd30;
    localparam logic [7:0] COL_FAR_RG   = 8'd10;
    localparam logic [7:0] COL_FAR_B    = 8'd50;
    localparam logic [7:0] COL_NEAR_R   = 8'd220;
    localparam logic [7:0] COL_NEAR_B   = 8'd0;
    localparam logic [7:0] COL_STEEP_G  = 8'd40;
    localparam logic [7:0] COL_MID_G    = 8'd130;
    localparam logic [7:0] COL_LOW_G    = 8'd220;
    localparam logic [7:0] COL_EVID_R   = 8'd0;
    localparam logic [7:0] COL_EVID_GB  = 8'd220;

    localparam logic signed [10:0] PITCH_STEEP = 11'sd150;
    localparam logic signed [10:0] PITCH_LOW   = 11'sd50;

    typedef enum logic [2:0] {
        REG_DISPLAY_MAX   = 3'd0,
        REG_NEAR_LIMIT    = 3'd1,
        REG_FAR_LIMIT     = 3'd2,
        REG_PITCH_TENTHS  = 3'd3,
        REG_INVERSE_SCALE = 3'd4,
        REG_INVERSE_MODE  = 3'd5,
        REG_CELL_WIDTH    = 3'd6,
        REG_CELL_HEIGHT   = 3'd7
    } dpc_reg_e;

    typedef enum logic [2:0] {
        CLS_INVALID,
        CLS_FAR,
        CLS_NEAR_STEEP,
        CLS_NEAR_MID,
        CLS_NEAR_LOW,
        CLS_EVIDENCE,
        CLS_GREY
    } dpc_cls_t;

    typedef struct packed {
        logic [23:0]           sample;
        logic                  sample_finite;
        logic [COORD_BITS-1:0] src_col;
        logic [COORD_BITS-1:0] src_row;
    } dpc_in_t;

    typedef struct packed {
        logic [7:0] raw_lum;
        logic [7:0] filter_red;
        logic [7:0] filter_green;
        logic [7:0] filter_blue;
        logic       grid_hit;
    } dpc_out_t;

    typedef struct packed {
        logic [15:0]           display_max;
        logic [15:0]           near_limit;
        logic [15:0]           far_limit;
        logic signed [10:0]    pitch_tenths;
        logic [15:0]           inverse_scale;
        logic                  inverse_mode;
        logic [COORD_BITS-1:0] cell_width;
        logic [COORD_BITS-1:0] cell_height;
    } dpc_cfg_t;

    typedef struct packed {
        logic                  vld;
        logic                  ok;
        logic [15:0]           depth;
        logic [COORD_BITS-1:0] col_rem;
        logic [COORD_BITS-1:0] row_rem;
    } dpc_front_t;

    typedef struct packed {
        logic     ok;
        dpc_cls_t cls;
    } dpc_side_t;

endpackage

// ===== src/depth_pixel_colorizer_unit.sv =====
`timescale 1ns / 1ps
// Every start produces exactly one done strobe, in the order the pixels came in.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// The pipeline holds the 16-step inverse divider, the 28 squaring steps of the
// log units and the 8-step ratio divider, each one register stage per step.
// Reset clears all valid bits and loads the register defaults; the receiver cannot stall.
module depth_pixel_colorizer_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dpc_pkg::dpc_in_t  pixel,
    output logic              done,
    output dpc_pkg::dpc_out_t result,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import dpc_pkg::*;

    dpc_cfg_t   cfg_reg;
    dpc_front_t front;
    logic       accept;

    logic [LOG_ARG_BITS-1:0] la_arg_reg;
    logic [LOG_ARG_BITS-1:0] lb_arg_reg;
    logic [LOG_ARG_BITS-1:0] la_arg_next;
    logic [LOG_ARG_BITS-1:0] lb_arg_next;
    logic [LOG_BITS-1:0]     la;
    logic [LOG_BITS-1:0]     lb;
    logic [7:0]              lum;
    logic [15:0]             dmax;
    logic [15:0]             dd;

    dpc_side_t side_reg     [0:SIDE_DEPTH];
    logic      side_vld_reg [0:SIDE_DEPTH];
    dpc_side_t side_next;

    logic     done_reg;
    dpc_out_t result_reg;
    dpc_out_t result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_max   <= 16'd5120;
            cfg_reg.near_limit    <= 16'd128;
            cfg_reg.far_limit     <= 16'd5120;
            cfg_reg.pitch_tenths  <= '0;
            cfg_reg.inverse_scale <= 16'd256;
            cfg_reg.inverse_mode  <= 1'b0;
            cfg_reg.cell_width    <= '0;
            cfg_reg.cell_height   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DISPLAY_MAX:   cfg_reg.display_max   <= cfg_data;
                REG_NEAR_LIMIT:    cfg_reg.near_limit    <= cfg_data;
                REG_FAR_LIMIT:     cfg_reg.far_limit     <= cfg_data;
                REG_PITCH_TENTHS:  cfg_reg.pitch_tenths  <= cfg_data[10:0];
                REG_INVERSE_SCALE: cfg_reg.inverse_scale <= cfg_data;
                REG_INVERSE_MODE:  cfg_reg.inverse_mode  <= cfg_data[0];
                REG_CELL_WIDTH:    cfg_reg.cell_width    <= cfg_data[COORD_BITS-1:0];
                REG_CELL_HEIGHT:   cfg_reg.cell_height   <= cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    dpc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pixel  (pixel),
        .cfg    (cfg_reg),
        .front  (front)
    );

    // classify and clamp the depth for the log units
    always_comb
    begin
        logic ev;
        dmax = (cfg_reg.display_max == '0) ? 16'd1 : cfg_reg.display_max;
        dd   = (front.depth < dmax) ? front.depth : dmax;
        la_arg_next = LOG_ARG_BITS'(dd) + LOG_ARG_BITS'(256);
        lb_arg_next = LOG_ARG_BITS'(dmax) + LOG_ARG_BITS'(256);
        ev = (cfg_reg.cell_width != '0) && (cfg_reg.cell_height != '0)
             && (front.col_rem == (cfg_reg.cell_width >> 1))
             && (front.row_rem == (cfg_reg.cell_height >> 1));
        side_next.ok = front.ok;
        if (!front.ok)
            side_next.cls = CLS_INVALID;
        else if (front.depth > cfg_reg.far_limit)
            side_next.cls = CLS_FAR;
        else if (front.depth < cfg_reg.near_limit)
        begin
            if (cfg_reg.pitch_tenths > PITCH_STEEP)
                side_next.cls = CLS_NEAR_STEEP;
            else if (cfg_reg.pitch_tenths < PITCH_LOW)
                side_next.cls = CLS_NEAR_LOW;
            else
                side_next.cls = CLS_NEAR_MID;
        end
        else if (ev)
            side_next.cls = CLS_EVIDENCE;
        else
            side_next.cls = CLS_GREY;
    end

    always_ff @(posedge clk)
    begin
        la_arg_reg  <= la_arg_next;
        lb_arg_reg  <= lb_arg_next;
        side_reg[0] <= side_next;
        for (int i = 1; i <= SIDE_DEPTH; i++)
            side_reg[i] <= side_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SIDE_DEPTH; i++)
                side_vld_reg[i] <= 1'b0;
        end
        else
        begin
            side_vld_reg[0] <= front.vld;
            for (int i = 1; i <= SIDE_DEPTH; i++)
                side_vld_reg[i] <= side_vld_reg[i-1];
        end
    end

    dpc_log u_log_depth (
        .clk      (clk),
        .arg      (la_arg_reg),
        .log2_val (la)
    );

    dpc_log u_log_max (
        .clk      (clk),
        .arg      (lb_arg_reg),
        .log2_val (lb)
    );

    dpc_ratio u_ratio (
        .clk (clk),
        .la  (la),
        .lb  (lb),
        .lum (lum)
    );

    always_comb
    begin
        result_next.raw_lum  = side_reg[SIDE_DEPTH].ok ? lum : 8'd0;
        result_next.grid_hit = (side_reg[SIDE_DEPTH].cls == CLS_EVIDENCE);
        case (side_reg[SIDE_DEPTH].cls)
            CLS_INVALID:
            begin
                result_next.filter_red   = COL_INVALID;
                result_next.filter_green = COL_INVALID;
                result_next.filter_blue  = COL_INVALID;
            end
            CLS_FAR:
            begin
                result_next.filter_red   = COL_FAR_RG;
                result_next.filter_green = COL_FAR_RG;
                result_next.filter_blue  = COL_FAR_B;
            end
            CLS_NEAR_STEEP:
            begin
                result_next.filter_red   = COL_NEAR_R;
                result_next.filter_green = COL_STEEP_G;
                result_next.filter_blue  = COL_NEAR_B;
            end
            CLS_NEAR_MID:
            begin
                result_next.filter_red   = COL_NEAR_R;
                result_next.filter_green = COL_MID_G;
                result_next.filter_blue  = COL_NEAR_B;
            end
            CLS_NEAR_LOW:
            begin
                result_next.filter_red   = COL_NEAR_R;
                result_next.filter_green = COL_LOW_G;
                result_next.filter_blue  = COL_NEAR_B;
            end
            CLS_EVIDENCE:
            begin
                result_next.filter_red   = COL_EVID_R;
                result_next.filter_green = COL_EVID_GB;
                result_next.filter_blue  = COL_EVID_GB;
            end
            default:
            begin
                result_next.filter_red   = result_next.raw_lum;
                result_next.filter_green = result_next.raw_lum;
                result_next.filter_blue  = result_next.raw_lum;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= side_vld_reg[SIDE_DEPTH];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("transaction did not complete on time");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching transaction");

    a_evidence: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.grid_hit |->
            result.filter_green == COL_EVID_GB && result.filter_blue == COL_EVID_GB)
        else $error("evidence flag without evidence colour");

endmodule

// ===== src/dpc_front.sv =====
`timescale 1ns / 1ps
module dpc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  dpc_pkg::dpc_in_t    pixel,
    input  dpc_pkg::dpc_cfg_t   cfg,
    output dpc_pkg::dpc_front_t front
);
    import dpc_pkg::*;

    typedef struct packed {
        logic                    ok;
        logic                    inv;
        logic                    sat;
        logic [15:0]             mdepth;
        logic [23:0]             dvs;
        logic [23:0]             rem;
        logic [15:0]             quo;
        logic [FRONT_STAGES-1:0] colb;
        logic [FRONT_STAGES-1:0] rowb;
        logic [COORD_BITS-1:0]   col_rem;
        logic [COORD_BITS-1:0]   row_rem;
    } fr_stage_t;

    fr_stage_t st_reg  [0:FRONT_STAGES];
    fr_stage_t st_next [0:FRONT_STAGES];
    logic      vld_reg [0:FRONT_STAGES];

    always_comb
    begin
        logic [24:0]           r2;
        logic [COORD_BITS:0]   c2;
        logic [COORD_BITS:0]   w2;
        st_next[0].inv     = cfg.inverse_mode;
        st_next[0].sat     = 24'(cfg.inverse_scale) >= pixel.sample;
        st_next[0].mdepth  = pixel.sample[15:0];
        st_next[0].dvs     = pixel.sample;
        st_next[0].rem     = 24'(cfg.inverse_scale);
        st_next[0].quo     = '0;
        st_next[0].colb    = FRONT_STAGES'(pixel.src_col);
        st_next[0].rowb    = FRONT_STAGES'(pixel.src_row);
        st_next[0].col_rem = '0;
        st_next[0].row_rem = '0;
        if (cfg.inverse_mode)
        begin
            st_next[0].ok = pixel.sample_finite && (pixel.sample != '0)
                            && (cfg.inverse_scale != '0);
        end
        else
        begin
            st_next[0].ok = pixel.sample_finite && (pixel.sample[15:0] != '0);
        end

        for (int s = 1; s <= FRONT_STAGES; s++)
        begin
            st_next[s] = st_reg[s-1];
            r2 = {st_reg[s-1].rem, 1'b0};
            if (r2 >= {1'b0, st_reg[s-1].dvs})
            begin
                st_next[s].rem = 24'(r2 - {1'b0, st_reg[s-1].dvs});
                st_next[s].quo = {st_reg[s-1].quo[14:0], 1'b1};
            end
            else
            begin
                st_next[s].rem = r2[23:0];
                st_next[s].quo = {st_reg[s-1].quo[14:0], 1'b0};
            end

            c2 = {st_reg[s-1].col_rem, st_reg[s-1].colb[FRONT_STAGES-1]};
            w2 = {1'b0, cfg.cell_width};
            if (c2 >= w2)
                st_next[s].col_rem = COORD_BITS'(c2 - w2);
            else
                st_next[s].col_rem = c2[COORD_BITS-1:0];
            st_next[s].colb = st_reg[s-1].colb << 1;

            c2 = {st_reg[s-1].row_rem, st_reg[s-1].rowb[FRONT_STAGES-1]};
            w2 = {1'b0, cfg.cell_height};
            if (c2 >= w2)
                st_next[s].row_rem = COORD_BITS'(c2 - w2);
            else
                st_next[s].row_rem = c2[COORD_BITS-1:0];
            st_next[s].rowb = st_reg[s-1].rowb << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= FRONT_STAGES; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int s = 1; s <= FRONT_STAGES; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= FRONT_STAGES; s++)
            st_reg[s] <= st_next[s];
    end

    always_comb
    begin
        front.vld     = vld_reg[FRONT_STAGES];
        front.ok      = st_reg[FRONT_STAGES].ok;
        front.col_rem = st_reg[FRONT_STAGES].col_rem;
        front.row_rem = st_reg[FRONT_STAGES].row_rem;
        if (!st_reg[FRONT_STAGES].inv)
            front.depth = st_reg[FRONT_STAGES].mdepth;
        else if (st_reg[FRONT_STAGES].sat)
            front.depth = 16'hFFFF;
        else
            front.depth = st_reg[FRONT_STAGES].quo;
    end

endmodule

// ===== src/dpc_log.sv =====
`timescale 1ns / 1ps
module dpc_log (
    input  logic                             clk,
    input  logic [dpc_pkg::LOG_ARG_BITS-1:0] arg,
    output logic [dpc_pkg::LOG_BITS-1:0]     log2_val
);
    import dpc_pkg::*;

    logic [4:0]          k_reg [0:LOG_FRAC];
    logic [30:0]         m_reg [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] f_reg [0:LOG_FRAC];
    logic [30:0]         m_next [1:LOG_FRAC];
    logic [LOG_FRAC-1:0] f_next [1:LOG_FRAC];
    logic [4:0]          k_next;
    logic [LOG_ARG_BITS+29:0] wide;

    always_comb
    begin
        k_next = '0;
        for (int i = 0; i < LOG_ARG_BITS; i++)
        begin
            if (arg[i])
                k_next = 5'(i);
        end
        wide = {arg, 30'b0} >> k_next;
    end

    always_comb
    begin
        logic [61:0] sq;
        for (int s = 1; s <= LOG_FRAC; s++)
        begin
            sq = {31'b0, m_reg[s-1]} * {31'b0, m_reg[s-1]};
            if (sq[61])
            begin
                m_next[s] = sq[61:31];
                f_next[s] = {f_reg[s-1][LOG_FRAC-2:0], 1'b1};
            end
            else
            begin
                m_next[s] = sq[60:30];
                f_next[s] = {f_reg[s-1][LOG_FRAC-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg[0] <= k_next;
        m_reg[0] <= wide[30:0];
        f_reg[0] <= '0;
        for (int s = 1; s <= LOG_FRAC; s++)
        begin
            k_reg[s] <= k_reg[s-1];
            m_reg[s] <= m_next[s];
            f_reg[s] <= f_next[s];
        end
    end

    assign log2_val = {k_reg[LOG_FRAC], f_reg[LOG_FRAC]};

endmodule

// ===== src/dpc_ratio.sv =====
`timescale 1ns / 1ps
module dpc_ratio (
    input  logic                         clk,
    input  logic [dpc_pkg::LOG_BITS-1:0] la,
    input  logic [dpc_pkg::LOG_BITS-1:0] lb,
    output logic [7:0]                   lum
);
    import dpc_pkg::*;

    logic [39:0] num_reg [0:RATIO_STAGES];
    logic [31:0] den_reg [0:RATIO_STAGES];
    logic [7:0]  q_reg   [0:RATIO_STAGES];
    logic [39:0] num_next [1:RATIO_STAGES];
    logic [7:0]  q_next   [1:RATIO_STAGES];
    logic [31:0] diff;
    logic [31:0] den;

    always_comb
    begin
        diff = 32'(lb - la);
        den  = 32'(lb - LOG_OF_256);
    end

    always_comb
    begin
        logic [39:0] sub;
        for (int s = 1; s <= RATIO_STAGES; s++)
        begin
            sub = 40'(den_reg[s-1]) << (RATIO_STAGES - s);
            if (num_reg[s-1] >= sub)
            begin
                num_next[s] = num_reg[s-1] - sub;
                q_next[s]   = {q_reg[s-1][6:0], 1'b1};
            end
            else
            begin
                num_next[s] = num_reg[s-1];
                q_next[s]   = {q_reg[s-1][6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg[0] <= 40'(diff) * 40'(LUM_SCALE);
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        for (int s = 1; s <= RATIO_STAGES; s++)
        begin
            num_reg[s] <= num_next[s];
            den_reg[s] <= den_reg[s-1];
            q_reg[s]   <= q_next[s];
        end
    end

    assign lum = q_reg[RATIO_STAGES];

endmodule
